// ===== rtl/core/lis_pkg.sv =====
// Shared types and constants for the longest increasing subsequence block.
// Holds the request/result structs and the token that moves down the cell row.
// No dependencies.
package lis_pkg;

  // Number of values stored per run, which is also the number of tail cells
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the result
  localparam int POS_W = 6;
  localparam int LEN_W = 7;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } req_t;

  typedef struct packed {
    logic signed [31:0] member_value;
    logic [POS_W-1:0]   member_position;
    logic [LEN_W-1:0]   sequence_length;
    logic               overflowed;
    logic               final_member;
  } res_t;

  // Search token handed from one tail cell to the next
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
  } token_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_WALK   = 3'b100
  } state_t;

endpackage

// ===== rtl/core/lis_cell.sv =====
// One tail cell of the patience search row.
// Depends on lis_pkg for the token type.
module lis_cell
  import lis_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   clear,
  input  token_t tok_in,
  output token_t tok_out,
  output logic   hit
);

  logic               occupied;
  logic signed [31:0] tail;

  // Token stops here at the first empty cell or the first tail not below it
  assign hit = tok_in.valid && (!occupied || (tail >= tok_in.key));

  // Cell contents; an equal key rewrites the same value
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      occupied <= 1'b0;
    end else if (hit) begin
      occupied <= 1'b1;
    end
    if (hit) begin
      tail <= tok_in.key;
    end
  end

  // Pass a token that did not stop to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid && !hit;
    end
    tok_out.key <= tok_in.key;
  end

endmodule

// ===== rtl/core/longest_increasing_subsequence.sv =====
// Longest strictly increasing subsequence, patience method.
// Depends on lis_pkg and lis_cell.
//
// Usage:
//   A request (value, is_last) is taken on a rising edge with start high and busy
//   low. Values form one run; is_last closes it. The first CAPACITY values of a
//   run are kept; later ones are dropped and set the overflowed flag.
//   Each kept value enters a row of CAPACITY tail cells and moves one cell per
//   cycle until it lands; its rank is the cell it lands in. A dropped value
//   does not enter the cell row.
//   After is_last the stored values are walked backward, one per cycle through
//   the value and rank memories, and the members come out highest position first,
//   each on result with result_strobe high for one cycle; busy stays high until the
//   last member is issued.
//   The receiver cannot stall: every strobed result must be taken.
//   Reset clears the state, the counters, the flags and the cell row; the memories
//   are not cleared and are only read where written in the current run.
module longest_increasing_subsequence
  import lis_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic result_strobe,
  output res_t result
);

  state_t             state;
  logic [CNT_W-1:0]   item_count;
  logic [CNT_W-1:0]   best_length;
  logic               overflow_flag;
  logic               last_q;
  logic [IDX_W-1:0]   hop;
  logic [CNT_W-1:0]   walk_idx;
  logic [CNT_W-1:0]   want;
  logic               rd_pend;
  logic [IDX_W-1:0]   rank_q;
  logic signed [31:0] value_q;
  token_t             inject;

  logic signed [31:0] stored_values [CAPACITY];
  logic [IDX_W-1:0]   ranks [CAPACITY];

  token_t             link [CAPACITY+1];
  logic [CAPACITY-1:0] hits;

  logic               accept;
  logic               full;
  logic               any_hit;
  logic               appended;
  logic               emit;
  logic               last_member;
  logic               clear_cells;
  logic [IDX_W-1:0]   wr_addr;
  logic [CNT_W-1:0]   rd_index;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign full        = (item_count == CNT_W'(CAPACITY));
  assign any_hit     = |hits;
  assign appended    = (CNT_W'(hop) == best_length);
  assign emit        = rd_pend && (rank_q == IDX_W'(want - 1'b1));
  assign last_member = (want == CNT_W'(1));
  assign clear_cells = (state == ST_WALK) && emit && last_member;
  assign wr_addr     = item_count[IDX_W-1:0];
  assign rd_index    = walk_idx - 1'b1;

  // Row of tail cells
  assign link[0] = inject;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lis_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear_cells),
      .tok_in  (link[i]),
      .tok_out (link[i+1]),
      .hit     (hits[i])
    );
  end

  // Value and rank memories: write on entry and on landing, read during the walk
  always_ff @(posedge clk) begin
    if (accept && !full) begin
      stored_values[wr_addr] <= request.value;
    end
    if (state == ST_SEARCH && any_hit) begin
      ranks[wr_addr] <= hop;
    end
    rank_q  <= ranks[rd_index[IDX_W-1:0]];
    value_q <= stored_values[rd_index[IDX_W-1:0]];
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      item_count    <= '0;
      best_length   <= '0;
      overflow_flag <= 1'b0;
      inject.valid  <= 1'b0;
      rd_pend       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      // A kept request enters the row; a matching rank read goes out
      inject.valid  <= accept && !full;
      result_strobe <= (state == ST_WALK) && emit;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q     <= request.is_last;
            inject.key <= request.value;
            hop        <= '0;
            if (full) begin
              overflow_flag <= 1'b1;
              if (request.is_last) begin
                state    <= ST_WALK;
                walk_idx <= item_count;
                want     <= best_length;
                rd_pend  <= 1'b0;
              end
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          hop <= hop + 1'b1;
          if (any_hit) begin
            item_count <= item_count + 1'b1;
            if (appended) begin
              best_length <= best_length + 1'b1;
            end
            if (last_q) begin
              state    <= ST_WALK;
              walk_idx <= item_count + 1'b1;
              want     <= appended ? (best_length + 1'b1) : best_length;
              rd_pend  <= 1'b0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_WALK: begin
          // Issue one read per cycle, newest entry first, until the last member
          if (walk_idx != '0 && !clear_cells) begin
            walk_idx <= rd_index;
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          // Emit when the rank read back is the one sought
          if (emit) begin
            result.member_value    <= value_q;
            result.member_position <= POS_W'(want - 1'b1);
            result.sequence_length <= LEN_W'(best_length);
            result.overflowed      <= overflow_flag;
            result.final_member    <= last_member;
            want                   <= want - 1'b1;
            if (last_member) begin
              state         <= ST_IDLE;
              item_count    <= '0;
              best_length   <= '0;
              overflow_flag <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
